/* hw/rtl/pth_pkg.sv */
// Shared types, constants and the microcode table of the point table hit test block.
package pth_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int COORD_W          = 10;
  localparam int ENTRY_W          = 6;
  localparam int COUNT_W          = 7;
  localparam int TOL_W            = 8;
  localparam int UPC_W            = 5;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_MOVE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [ENTRY_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] hit_index;
    logic               hit_found;
    status_e            status;
    logic [COUNT_W-1:0] point_count;
  } res_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef enum logic [3:0] {
    COND_ALWAYS   = 4'd0,
    COND_START    = 4'd1,
    COND_KIND     = 4'd2,
    COND_FULL     = 4'd3,
    COND_BAD_IDX  = 4'd4,
    COND_EMPTY    = 4'd5,
    COND_LAST     = 4'd6,
    COND_SCAN_END = 4'd7,
    COND_HIT      = 4'd8
  } cond_e;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_IDX  = 2'd1,
    PTR_ZERO = 2'd2,
    PTR_INC  = 2'd3
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [1:0] {
    WA_CNT = 2'd0,
    WA_PTR = 2'd1,
    WA_IDX = 2'd2
  } wa_sel_e;

  typedef enum logic {
    WD_REQ  = 1'b0,
    WD_READ = 1'b1
  } wd_sel_e;

  typedef enum logic {
    RA_PTR  = 1'b0,
    RA_NEXT = 1'b1
  } ra_sel_e;

  // One control word per microcode step.
  typedef struct packed {
    cond_e   cond;
    logic    cond_inv;
    upc_t    target;
    ptr_op_e ptr_op;
    logic    hidx_ld;
    cnt_op_e cnt_op;
    logic    mem_we;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    ra_sel_e ra_sel;
    logic    done;
    status_e status;
    logic    found;
  } ctrl_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  bad_idx;
    logic  empty;
    logic  last;
    logic  scan_end;
    logic  hit;
  } flags_t;

  // Step addresses. The four dispatch stubs follow the kind encoding.
  localparam upc_t STEP_IDLE    = 5'd0;
  localparam upc_t STEP_DISP    = 5'd1;
  localparam upc_t STEP_J_ADD   = 5'd2;
  localparam upc_t STEP_J_REM   = 5'd3;
  localparam upc_t STEP_J_SEL   = 5'd4;
  localparam upc_t STEP_J_MOV   = 5'd5;
  localparam upc_t STEP_A0      = 5'd6;
  localparam upc_t STEP_A1      = 5'd7;
  localparam upc_t STEP_R0      = 5'd8;
  localparam upc_t STEP_R1      = 5'd9;
  localparam upc_t STEP_R2      = 5'd10;
  localparam upc_t STEP_R3      = 5'd11;
  localparam upc_t STEP_S0      = 5'd12;
  localparam upc_t STEP_S1      = 5'd13;
  localparam upc_t STEP_S2      = 5'd14;
  localparam upc_t STEP_D_HIT   = 5'd15;
  localparam upc_t STEP_M0      = 5'd16;
  localparam upc_t STEP_M1      = 5'd17;
  localparam upc_t STEP_D_OK    = 5'd18;
  localparam upc_t STEP_D_FULL  = 5'd19;
  localparam upc_t STEP_D_RANGE = 5'd20;
  localparam upc_t STEP_D_MISS  = 5'd21;

  localparam ctrl_t UOP_NOP = '{
    cond:     COND_ALWAYS,
    cond_inv: 1'b0,
    target:   STEP_IDLE,
    ptr_op:   PTR_HOLD,
    hidx_ld:  1'b0,
    cnt_op:   CNT_HOLD,
    mem_we:   1'b0,
    wa_sel:   WA_CNT,
    wd_sel:   WD_REQ,
    ra_sel:   RA_PTR,
    done:     1'b0,
    status:   STATUS_OK,
    found:    1'b0
  };

  // Microcode table. A true condition (after inversion) jumps to target,
  // otherwise fall through to the next step; COND_KIND jumps to target + kind.
  function automatic ctrl_t uop_rom(upc_t addr);
    ctrl_t w;
    w = UOP_NOP;
    case (addr)
      STEP_IDLE: begin
        w.cond     = COND_START;
        w.cond_inv = 1'b1;
        w.target   = STEP_IDLE;
      end
      STEP_DISP: begin
        w.cond   = COND_KIND;
        w.target = STEP_J_ADD;
      end
      STEP_J_ADD: w.target = STEP_A0;
      STEP_J_REM: w.target = STEP_R0;
      STEP_J_SEL: w.target = STEP_S0;
      STEP_J_MOV: w.target = STEP_M0;
      STEP_A0: begin
        w.cond   = COND_FULL;
        w.target = STEP_D_FULL;
      end
      STEP_A1: begin
        w.mem_we = 1'b1;
        w.wa_sel = WA_CNT;
        w.wd_sel = WD_REQ;
        w.cnt_op = CNT_INC;
        w.target = STEP_D_OK;
      end
      STEP_R0: begin
        w.cond   = COND_BAD_IDX;
        w.target = STEP_D_RANGE;
        w.ptr_op = PTR_IDX;
      end
      STEP_R1: begin
        w.cond   = COND_LAST;
        w.target = STEP_R3;
        w.ra_sel = RA_NEXT;
      end
      STEP_R2: begin
        w.mem_we = 1'b1;
        w.wa_sel = WA_PTR;
        w.wd_sel = WD_READ;
        w.ptr_op = PTR_INC;
        w.target = STEP_R1;
      end
      STEP_R3: begin
        w.cnt_op = CNT_DEC;
        w.target = STEP_D_OK;
      end
      STEP_S0: begin
        w.cond   = COND_EMPTY;
        w.target = STEP_D_RANGE;
        w.ptr_op = PTR_ZERO;
      end
      STEP_S1: begin
        w.cond   = COND_SCAN_END;
        w.target = STEP_D_MISS;
        w.ra_sel = RA_PTR;
      end
      STEP_S2: begin
        w.cond     = COND_HIT;
        w.cond_inv = 1'b1;
        w.target   = STEP_S1;
        w.ptr_op   = PTR_INC;
        w.hidx_ld  = 1'b1;
      end
      STEP_D_HIT: begin
        w.done  = 1'b1;
        w.found = 1'b1;
      end
      STEP_M0: begin
        w.cond   = COND_BAD_IDX;
        w.target = STEP_D_RANGE;
      end
      STEP_M1: begin
        w.mem_we = 1'b1;
        w.wa_sel = WA_IDX;
        w.wd_sel = WD_REQ;
        w.target = STEP_D_OK;
      end
      STEP_D_OK:   w.done = 1'b1;
      STEP_D_MISS: w.done = 1'b1;
      STEP_D_FULL: begin
        w.done   = 1'b1;
        w.status = STATUS_FULL;
      end
      STEP_D_RANGE: begin
        w.done   = 1'b1;
        w.status = STATUS_RANGE;
      end
      default: w = UOP_NOP;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/pth_seq.sv */
// Microcode sequencer: step counter, control table lookup and jump logic.
module pth_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pth_pkg::flags_t flags_i,
  output pth_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);
  import pth_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t ctrl;
  logic  cond_val;
  logic  take;

  assign ctrl = uop_rom(upc_q);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   cond_val = 1'b1;
      COND_START:    cond_val = start_i;
      COND_KIND:     cond_val = 1'b1;
      COND_FULL:     cond_val = flags_i.full;
      COND_BAD_IDX:  cond_val = flags_i.bad_idx;
      COND_EMPTY:    cond_val = flags_i.empty;
      COND_LAST:     cond_val = flags_i.last;
      COND_SCAN_END: cond_val = flags_i.scan_end;
      COND_HIT:      cond_val = flags_i.hit;
      default:       cond_val = 1'b1;
    endcase
  end

  assign take = cond_val ^ ctrl.cond_inv;

  always_comb begin
    if (ctrl.cond == COND_KIND) begin
      upc_d = ctrl.target + upc_t'(flags_i.kind);
    end else if (take) begin
      upc_d = ctrl.target;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (upc_q != STEP_IDLE);

endmodule

/* hw/rtl/pth_dp.sv */
// Datapath: point memory, count, pointer, hit-box compare and result register.
module pth_dp #(
  parameter int CAPACITY = pth_pkg::CAPACITY_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  pth_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  logic [pth_pkg::TOL_W-1:0] cfg_data_i,
  input  pth_pkg::ctrl_t            ctrl_i,
  output pth_pkg::flags_t           flags_o,
  output logic                      res_valid_o,
  output pth_pkg::res_t             res_o
);
  import pth_pkg::*;

  localparam int IdxW  = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int WideW = (CntW > COUNT_W) ? CntW : COUNT_W;

  req_t              req_q;
  logic [TOL_W-1:0]  tol_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   ptr_nx;
  logic [CntW-1:0]   hidx_q;
  point_t            rd_q;
  point_t            mem_q [CAPACITY];
  point_t            wdata;
  logic [IdxW-1:0]   waddr;
  logic [IdxW-1:0]   raddr;
  logic [WideW-1:0]  idx_w;
  logic [WideW-1:0]  cnt_w;
  logic [WideW-1:0]  hidx_w;
  logic [COORD_W-1:0] dx, dy;
  logic              res_valid_q;
  res_t              res_q;

  assign idx_w  = WideW'(req_q.entry_index);
  assign cnt_w  = WideW'(cnt_q);
  assign hidx_w = WideW'(hidx_q);
  assign ptr_nx = ptr_q + CntW'(1);

  // Absolute coordinate distances to the point just read.
  assign dx = (req_q.x_coord >= rd_q.x) ? (req_q.x_coord - rd_q.x) : (rd_q.x - req_q.x_coord);
  assign dy = (req_q.y_coord >= rd_q.y) ? (req_q.y_coord - rd_q.y) : (rd_q.y - req_q.y_coord);

  always_comb begin
    flags_o.kind     = req_q.kind;
    flags_o.full     = (cnt_q >= CntW'(CAPACITY));
    flags_o.empty    = (cnt_q == '0);
    flags_o.bad_idx  = (cnt_q == '0) || (idx_w >= cnt_w);
    flags_o.last     = (ptr_nx >= cnt_q);
    flags_o.scan_end = (ptr_q >= cnt_q);
    flags_o.hit      = (dx <= COORD_W'(tol_q)) && (dy <= COORD_W'(tol_q));
  end

  always_comb begin
    case (ctrl_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_IDX:  ptr_d = idx_w[CntW-1:0];
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_nx;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + CntW'(1);
      CNT_DEC:  cnt_d = cnt_q - CntW'(1);
      default:  cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.wa_sel)
      WA_CNT:  waddr = cnt_q[IdxW-1:0];
      WA_PTR:  waddr = ptr_q[IdxW-1:0];
      WA_IDX:  waddr = idx_w[IdxW-1:0];
      default: waddr = cnt_q[IdxW-1:0];
    endcase
  end

  always_comb begin
    case (ctrl_i.wd_sel)
      WD_REQ:  wdata = '{x: req_q.x_coord, y: req_q.y_coord};
      WD_READ: wdata = rd_q;
      default: wdata = rd_q;
    endcase
  end

  assign raddr = (ctrl_i.ra_sel == RA_NEXT) ? ptr_nx[IdxW-1:0] : ptr_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_RESET;
      cnt_q       <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      res_valid_q <= ctrl_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_i;
    end
    if (ctrl_i.hidx_ld) begin
      hidx_q <= ptr_q;
    end
    if (ctrl_i.done) begin
      res_q.hit_index   <= ctrl_i.found ? hidx_w[ENTRY_W-1:0] : '0;
      res_q.hit_found   <= ctrl_i.found;
      res_q.status      <= ctrl_i.status;
      res_q.point_count <= cnt_w[COUNT_W-1:0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/point_table_hit_test.sv */
// Top level of the point table hit test block: sequencer plus datapath.
//
// Channel   Direction  Handshake                        Payload
// request   in         start high and busy low          req_i (kind, x, y, entry index)
// result    out        res_valid_o strobe, one cycle    res_o (hit index, found, status, count)
// config    in         cfg_valid_i and cfg_ready_o      cfg_data_i (hit tolerance)
//
// Add and move write a single entry. Remove at index i and select run a loop
//   over the stored points: the memory read, registered, followed by a
//   shift-down write or a box compare. Rejected requests skip the loop.
// busy is low again in the cycle the strobe shows, so the next request may be
//   accepted there. Reset clears the count to zero and the tolerance to 10; the
//   point memory is not cleared. The receiver cannot stall results.
module point_table_hit_test #(
  parameter int CAPACITY = pth_pkg::CAPACITY_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pth_pkg::req_t             req_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pth_pkg::TOL_W-1:0] cfg_data_i,
  output logic                      res_valid_o,
  output pth_pkg::res_t             res_o
);
  import pth_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  // Take a request only while the sequencer sits in its idle step.
  assign accept = start & ~busy;

  // Tolerance writes land in a single register; always ready.
  assign cfg_ready_o = 1'b1;

  // Step through the control table; hold in idle until a request arrives.
  pth_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // Latch the request, walk the point memory and register the result.
  pth_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* hw/rtl/pth_chk.sv */
// Port-level checker of the point table hit test block and its bind.
module pth_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input pth_pkg::res_t res_o
);
  import pth_pkg::*;

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Every end of work delivers a result.
  a_fell_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result");

  // A result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  // A hit carries status ok; no hit carries index zero.
  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((res_o.hit_found && res_o.status == STATUS_OK) ||
                     (!res_o.hit_found && res_o.hit_index == '0)))
    else $error("inconsistent hit fields");

endmodule

bind point_table_hit_test pth_chk u_pth_chk (.*);
